>>> sv/ita_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
package ita_pkg;

   localparam int MAX_CHARS = 64;

   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

   localparam logic [1:0] FUNC_UDEC = 2'd0;
   localparam logic [1:0] FUNC_SDEC = 2'd1;
   localparam logic [1:0] FUNC_HEX  = 2'd2;
   localparam logic [1:0] FUNC_BIN  = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic [6:0]  width;
      logic [6:0]  precision;
      logic [6:0]  space_left;
      logic        left_justify;
      logic        zero_pad;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

endpackage

>>> sv/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: sequencer, digit store and emitter.
//
// One request at a time: req_stall is high from acceptance until the last character
// has been handed to the output register. Zero values skip digit generation.
// Decimal runs each divide-by-ten step in two phases (multiply, then remainder)
// through a single shared reciprocal multiplier, up to 9 steps plus a final digit;
// hex and binary scan down from the top nibble for the first nonzero one. The set-up
// states ST_SETUP and ST_BOUND follow, then one character per cycle while the output
// side takes them; at most MAX_CHARS characters are emitted.
module integer_to_ascii_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ita_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ita_pkg::rsp_type  rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_SETUP = 6'b001000,
      ST_BOUND = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  func_ff, func_in;
   logic [31:0] value_ff, value_in;
   logic [6:0]  width_ff, width_in;
   logic [6:0]  prec_ff, prec_in;
   logic [6:0]  room_ff, room_in;
   logic        left_ff, left_in;
   logic        zpad_ff, zpad_in;
   logic        zero_ff, zero_in;
   logic        sign_ff, sign_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] quot_ff, quot_in;
   logic        phase_ff, phase_in;
   logic [3:0]  nd_ff, nd_in;
   logic [2:0]  nib_ff, nib_in;
   logic        cs_ff, cs_in;
   logic [6:0]  ca_ff, ca_in;
   logic [6:0]  cb_ff, cb_in;
   logic [6:0]  cd_ff, cd_in;
   logic [6:0]  ct_ff, ct_in;
   logic [7:0]  pad_char_ff, pad_char_in;
   logic [4:0]  didx_ff, didx_in;
   logic [6:0]  e1_ff, e1_in;
   logic [6:0]  e2_ff, e2_in;
   logic [6:0]  e3_ff, e3_in;
   logic [6:0]  e4_ff, e4_in;
   logic [6:0]  last_pos_ff, last_pos_in;
   logic [6:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ita_pkg::rsp_type rsp_ff, rsp_in;

   logic [3:0]  dg_ff [10];
   logic        dg_we;
   logic [3:0]  dg_wdata;

   logic [31:0] div_q;
   logic [31:0] rem_full;
   logic [3:0]  top_nib;
   logic [2:0]  top_bits;
   logic [5:0]  bit_total;
   logic [6:0]  raw_num, num, p_len, w_len, gap;
   logic [3:0]  hex_nib;
   logic [7:0]  digit_char;
   logic [7:0]  emit_char;
   logic        in_digits;
   logic        out_free;
   logic        emit_last;

   ita_div10 u_div10 (
      .dividend (mag_ff),
      .quotient (div_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rem_full = mag_ff - ((quot_ff << 3) + (quot_ff << 1));
   assign top_nib  = value_ff[{nib_ff, 2'b00} +: 4];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (top_nib[3]) begin
         top_bits = 3'd4;
      end else if (top_nib[2]) begin
         top_bits = 3'd3;
      end else if (top_nib[1]) begin
         top_bits = 3'd2;
      end else begin
         top_bits = 3'd1;
      end
      bit_total = {1'b0, nib_ff, 2'b00} + {3'b0, top_bits};

      case (func_ff)
         ita_pkg::FUNC_HEX: raw_num = {3'b0, ({1'b0, nib_ff} + 4'd1)};
         ita_pkg::FUNC_BIN: raw_num = {1'b0, bit_total};
         default:           raw_num = {3'b0, nd_ff} + {6'b0, sign_ff};
      endcase
      num   = (raw_num > room_ff) ? room_ff : raw_num;
      p_len = (prec_ff > num) ? prec_ff : num;
      w_len = (width_ff > num) ? width_ff : num;
      gap   = (w_len > p_len) ? (w_len - p_len) : 7'd0;

      hex_nib = value_ff[{didx_ff[2:0], 2'b00} +: 4];
      case (func_ff)
         ita_pkg::FUNC_HEX: begin
            if (hex_nib >= 4'd10) begin
               digit_char = {4'b0, hex_nib} + ita_pkg::HEX_ALPHA_OFS;
            end else begin
               digit_char = {4'b0, hex_nib} + ita_pkg::CHAR_ZERO;
            end
         end
         ita_pkg::FUNC_BIN: digit_char = {7'b0, value_ff[didx_ff]} + ita_pkg::CHAR_ZERO;
         default:           digit_char = {4'b0, dg_ff[didx_ff[3:0]]} + ita_pkg::CHAR_ZERO;
      endcase

      in_digits = 1'b0;
      if (pos_ff < e1_ff) begin
         emit_char = ita_pkg::CHAR_MINUS;
      end else if (pos_ff < e2_ff) begin
         emit_char = pad_char_ff;
      end else if (pos_ff < e3_ff) begin
         emit_char = ita_pkg::CHAR_ZERO;
      end else if (pos_ff < e4_ff) begin
         emit_char = digit_char;
         in_digits = 1'b1;
      end else begin
         emit_char = ita_pkg::CHAR_SPACE;
      end
      emit_last = (pos_ff == last_pos_ff);
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      room_in      = room_ff;
      left_in      = left_ff;
      zpad_in      = zpad_ff;
      zero_in      = zero_ff;
      sign_in      = sign_ff;
      mag_in       = mag_ff;
      quot_in      = quot_ff;
      phase_in     = phase_ff;
      nd_in        = nd_ff;
      nib_in       = nib_ff;
      cs_in        = cs_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      cd_in        = cd_ff;
      ct_in        = ct_ff;
      pad_char_in  = pad_char_ff;
      didx_in      = didx_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      e3_in        = e3_ff;
      e4_in        = e4_ff;
      last_pos_in  = last_pos_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      dg_we        = 1'b0;
      dg_wdata     = mag_ff[3:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_data.func;
               value_in = req_data.value;
               width_in = req_data.width;
               prec_in  = req_data.precision;
               room_in  = (req_data.space_left == 7'd0) ? 7'd1 : req_data.space_left;
               left_in  = req_data.left_justify;
               zpad_in  = req_data.zero_pad;
               zero_in  = (req_data.value == 32'd0);
               sign_in  = (req_data.func == ita_pkg::FUNC_SDEC) && req_data.value[31];
               mag_in   = sign_in ? (32'd0 - req_data.value) : req_data.value;
               nd_in    = 4'd0;
               phase_in = 1'b0;
               nib_in   = 3'd7;
               if (zero_in) begin
                  state_in = ST_SETUP;
               end else if (req_data.func == ita_pkg::FUNC_UDEC ||
                            req_data.func == ita_pkg::FUNC_SDEC) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DIV: begin
            if (!phase_ff) begin
               if (mag_ff >= 32'd10) begin
                  quot_in  = div_q;
                  phase_in = 1'b1;
               end else begin
                  // final, most significant digit
                  dg_we    = 1'b1;
                  dg_wdata = mag_ff[3:0];
                  nd_in    = nd_ff + 4'd1;
                  state_in = ST_SETUP;
               end
            end else begin
               dg_we    = 1'b1;
               dg_wdata = rem_full[3:0];
               nd_in    = nd_ff + 4'd1;
               mag_in   = quot_ff;
               phase_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // value is nonzero here, so some nibble stops the scan
            if (top_nib != 4'd0) begin
               state_in = ST_SETUP;
            end else begin
               nib_in = nib_ff - 3'd1;
            end
         end
         ST_SETUP: begin
            cs_in       = 1'b0;
            ca_in       = 7'd0;
            ct_in       = 7'd0;
            pad_char_in = ita_pkg::CHAR_SPACE;
            cb_in       = p_len - num;
            cd_in       = num;
            didx_in     = num[4:0] - 5'd1;
            if (zero_ff) begin
               cb_in = 7'd1;
               cd_in = 7'd0;
            end else begin
               case (func_ff)
                  ita_pkg::FUNC_HEX: begin
                     ca_in = left_ff ? 7'd0 : gap;
                     ct_in = left_ff ? gap : 7'd0;
                     if (!left_ff && zpad_ff) begin
                        pad_char_in = ita_pkg::CHAR_ZERO;
                     end
                  end
                  ita_pkg::FUNC_BIN: begin
                     ca_in = 7'd0;
                  end
                  default: begin
                     cs_in   = sign_ff;
                     cd_in   = num - {6'b0, sign_ff};
                     didx_in = {1'b0, nd_ff} - 5'd1;
                  end
               endcase
            end
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            e1_in = {6'b0, cs_ff};
            e2_in = e1_in + ca_ff;
            e3_in = e2_in + cb_ff;
            e4_in = e3_in + cd_ff;
            if (int'(e4_in + ct_ff) > ita_pkg::MAX_CHARS) begin
               last_pos_in = 7'(ita_pkg::MAX_CHARS - 1);
            end else begin
               last_pos_in = e4_in + ct_ff - 7'd1;
            end
            pos_in   = 7'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.char_out = emit_char;
               rsp_in.last     = emit_last;
               if (in_digits) begin
                  didx_in = didx_ff - 5'd1;
               end
               pos_in = pos_ff + 7'd1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      value_ff    <= value_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      room_ff     <= room_in;
      left_ff     <= left_in;
      zpad_ff     <= zpad_in;
      zero_ff     <= zero_in;
      sign_ff     <= sign_in;
      mag_ff      <= mag_in;
      quot_ff     <= quot_in;
      phase_ff    <= phase_in;
      nd_ff       <= nd_in;
      nib_ff      <= nib_in;
      cs_ff       <= cs_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      cd_ff       <= cd_in;
      ct_ff       <= ct_in;
      pad_char_ff <= pad_char_in;
      didx_ff     <= didx_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      e3_ff       <= e3_in;
      e4_ff       <= e4_in;
      last_pos_ff <= last_pos_in;
      pos_ff      <= pos_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (dg_we) begin
         dg_ff[nd_ff] <= dg_wdata;
      end
   end

endmodule

>>> sv/ita_div10.sv
// Divide-by-ten step: reciprocal multiply giving the exact 32-bit quotient.
module ita_div10 (
   input  logic [31:0] dividend,
   output logic [31:0] quotient
);

   logic [63:0] product;

   assign product  = {32'b0, dividend} * {32'b0, ita_pkg::RECIP_TEN};
   assign quotient = 32'(product >> ita_pkg::RECIP_SHIFT);

endmodule
